// ===== src/session_retry_timer_table_core_assert.svh =====
// Assertion macros for the session retry timer table core.
// Used by modules that have clk and arst_n in scope.
`ifndef SESSION_RETRY_TIMER_TABLE_CORE_ASSERT_SVH
`define SESSION_RETRY_TIMER_TABLE_CORE_ASSERT_SVH

// Hold cons in the same cycle as ante.
`define SRTT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Hold cons in the cycle after ante.
`define SRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/srtt_pkg.sv =====
// Shared types and constants for the session retry timer table core.
// No dependencies.
`timescale 1ns / 1ps

package srtt_pkg;

	localparam int IdW        = 8;
	localparam int TimerW     = 16;
	localparam int RetryW     = 8;
	localparam int CfgIdxW    = 1;
	localparam int CfgW       = 16;
	localparam int MaxResults = 16;
	localparam int EvCntW     = 5;

	localparam logic [TimerW-1:0] TimeoutReset = 16'd3000;
	localparam logic [RetryW-1:0] RetryReset   = 8'd3;
	localparam logic [IdW-1:0]    IdReset      = 8'd1;
	localparam logic [IdW-1:0]    IdMax        = 8'd255;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_ARM   = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_ALLOC  = 2'd0,
		EV_RETX   = 2'd1,
		EV_EXPIRE = 2'd2
	} event_kind_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TIMEOUT = 1'b0,
		CFG_RETRY   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [IdW-1:0]    id;
		logic              waiting;
		logic [RetryW-1:0] retries;
		logic [TimerW-1:0] timer;
	} entry_t;

	typedef struct packed {
		logic        due;
		event_kind_t kind;
	} tick_res_t;

	typedef struct packed {
		logic clr;
		logic scan;
	} alloc_ctl_t;

endpackage

// ===== src/srtt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read.
// No dependencies.
`timescale 1ns / 1ps

module srtt_ram #(
	parameter int WIDTH = 33,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/srtt_tick_upd.sv =====
// Per-entry timer update for a tick: saturating countdown, reload or expiry.
// Depends on srtt_pkg.
`timescale 1ns / 1ps

module srtt_tick_upd import srtt_pkg::*; (
	input  entry_t              ent,
	input  logic [TimerW-1:0]   elapsed,
	input  logic [TimerW-1:0]   timeout,
	input  logic [RetryW-1:0]   limit,
	output entry_t              nxt,
	output tick_res_t           res
);

	logic [TimerW-1:0] left;

	always_comb begin
		left = (ent.timer > elapsed) ? (ent.timer - elapsed) : '0;
		nxt = ent;
		res.due = 1'b0;
		res.kind = EV_RETX;
		if (ent.waiting) begin
			nxt.timer = left;
			if (left == '0) begin
				res.due = 1'b1;
				if (ent.retries < limit) begin
					nxt.timer = timeout;
					nxt.retries = ent.retries + 1'b1;
					res.kind = EV_RETX;
				end else begin
					nxt.waiting = 1'b0;
					res.kind = EV_EXPIRE;
				end
			end
		end
	end

endmodule

// ===== src/srtt_id_alloc.sv =====
// Free id search: marks ids in use near next_id during a table scan,
// then picks the first unused one. Depends on srtt_pkg.
`timescale 1ns / 1ps

module srtt_id_alloc import srtt_pkg::*; #(
	parameter int SESSIONS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  alloc_ctl_t      ctl,
	input  logic [IdW-1:0]  ent_id,
	input  logic [IdW-1:0]  next_id,
	output logic [IdW-1:0]  pick_id,
	output logic [IdW-1:0]  after_id
);

	localparam int SlotW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

	logic [SESSIONS-1:0] used_q;
	logic [IdW:0]        diff;
	logic [IdW:0]        off;
	logic [SlotW-1:0]    sel;
	logic [IdW:0]        sum;

	always_comb begin
		diff = {1'b0, ent_id} - {1'b0, next_id};
		off  = diff[IdW] ? (diff + {1'b0, IdMax}) : diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (ctl.clr) begin
			used_q <= '0;
		end else if (ctl.scan && ent_id != '0 && off < (IdW+1)'(SESSIONS)) begin
			used_q[off[SlotW-1:0]] <= 1'b1;
		end
	end

	always_comb begin
		sel = '0;
		for (int i = SESSIONS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				sel = SlotW'(i);
			end
		end
		sum = {1'b0, next_id} + (IdW+1)'(sel);
		if (sum > {1'b0, IdMax}) begin
			sum = sum - {1'b0, IdMax};
		end
		pick_id  = sum[IdW-1:0];
		after_id = (pick_id == IdMax) ? IdReset : (pick_id + 1'b1);
	end

endmodule

// ===== src/session_retry_timer_table_core.sv =====
// Session retry timer table: a table of SESSIONS sessions held in one RAM word per
// entry, walked one entry per cycle through a single read port, unless a tick event
// waits on a stalled output, and written back. An item is accepted, the table is
// streamed through the RAM read port, then the last word is written back or flushed;
// a stalled output holds it longer. Allocate and tick give their words through a
// one-word output register; the last word of an item carries last_event. Reset needs
// no clearing pass: per-entry valid flags make unwritten entries read as free.
// Depends on srtt_pkg, srtt_ram, srtt_tick_upd, srtt_id_alloc.
`timescale 1ns / 1ps

module session_retry_timer_table_core import srtt_pkg::*; #(
	parameter int SESSIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [IdW-1:0]     sess_id,
	input  logic [TimerW-1:0]  elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic [IdW-1:0]     event_id,
	output logic               last_event,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	`include "session_retry_timer_table_core_assert.svh"

	localparam int SlotW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int CntW  = $clog2(SESSIONS + 1);
	localparam int EntW  = $bits(entry_t);

	state_t            state_q, state_d;
	action_t           act_q;
	logic [IdW-1:0]    sid_q;
	logic [TimerW-1:0] elap_q;
	logic [TimerW-1:0] timeout_q;
	logic [RetryW-1:0] limit_q;
	logic [IdW-1:0]    next_id_q;
	logic [SESSIONS-1:0] valid_q;

	logic [CntW-1:0]   rd_cnt_q;
	logic              s1_vld_s1;
	logic [SlotW-1:0]  addr_s1;
	logic              vbit_s1;

	logic              found_q;
	logic [SlotW-1:0]  slot_q;
	entry_t            ent_q;

	logic              pend_vld_q;
	event_kind_t       pend_kind_q;
	logic [IdW-1:0]    pend_id_q;
	logic [EvCntW-1:0] ev_cnt_q;

	logic              out_vld_q;
	event_kind_t       out_kind_q;
	logic [IdW-1:0]    out_id_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;
	logic              scan_more;
	logic              issue;
	logic              hold;
	logic              s1_adv;
	logic              rec;
	logic              match;
	logic              is_tick;
	logic [SlotW-1:0]  raddr;
	logic              ram_we;
	logic [SlotW-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [EntW-1:0]   ram_rdata;
	entry_t            ent_s1;
	entry_t            upd;
	tick_res_t         res;
	alloc_ctl_t        actl;
	logic [IdW-1:0]    pick_id;
	logic [IdW-1:0]    after_id;
	logic              push;
	event_kind_t       push_kind;
	logic [IdW-1:0]    push_id;
	logic              push_last;
	logic              alloc_done;

	srtt_ram #(
		.WIDTH(EntW),
		.DEPTH(SESSIONS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(EntW'(ram_wdata)),
		.re   (issue),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	srtt_tick_upd u_tick (
		.ent    (ent_s1),
		.elapsed(elap_q),
		.timeout(timeout_q),
		.limit  (limit_q),
		.nxt    (upd),
		.res    (res)
	);

	srtt_id_alloc #(
		.SESSIONS(SESSIONS)
	) u_id (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (actl),
		.ent_id  (ent_s1.id),
		.next_id (next_id_q),
		.pick_id (pick_id),
		.after_id(after_id)
	);

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_vld_q || !out_stall;
	assign ent_s1    = vbit_s1 ? entry_t'(ram_rdata) : '0;
	assign is_tick   = (act_q == ACT_TICK);
	assign rec       = res.due && (ev_cnt_q < EvCntW'(MaxResults));
	assign hold      = is_tick && rec && pend_vld_q && !out_free;
	assign s1_adv    = s1_vld_s1 && !hold && (state_q == ST_SCAN);
	assign scan_more = rd_cnt_q < CntW'(SESSIONS);
	assign raddr     = rd_cnt_q[SlotW-1:0];
	assign match     = (act_q == ACT_ALLOC) ? (ent_s1.id == '0) :
		(sid_q != '0 && ent_s1.id == sid_q);
	assign actl      = '{clr: accept, scan: s1_adv && (act_q == ACT_ALLOC)};

	assign out_valid  = out_vld_q;
	assign event_kind = out_kind_q;
	assign event_id   = out_id_q;
	assign last_event = out_last_q;

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		issue      = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = addr_s1;
		ram_wdata  = upd;
		push       = 1'b0;
		push_kind  = pend_kind_q;
		push_id    = pend_id_q;
		push_last  = 1'b0;
		alloc_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = scan_more && (!s1_vld_s1 || s1_adv);
				if (s1_adv && is_tick && ent_s1.waiting) begin
					ram_we = 1'b1;
				end
				if (s1_adv && is_tick && rec && pend_vld_q) begin
					push = 1'b1;
				end
				if (!scan_more && (!s1_vld_s1 || s1_adv)) begin
					state_d = is_tick ? ST_DRAIN : ST_FINISH;
				end
			end
			ST_FINISH: begin
				ram_waddr = slot_q;
				case (act_q)
					ACT_ALLOC: begin
						if (out_free) begin
							push       = 1'b1;
							push_kind  = EV_ALLOC;
							push_id    = found_q ? pick_id : '0;
							push_last  = 1'b1;
							alloc_done = found_q;
							ram_we     = found_q;
							ram_wdata  = '{id: pick_id, waiting: 1'b0,
								retries: ent_q.retries, timer: timeout_q};
							state_d    = ST_IDLE;
						end
					end
					ACT_ARM: begin
						ram_we    = found_q;
						ram_wdata = '{id: ent_q.id, waiting: 1'b1,
							retries: '0, timer: timeout_q};
						state_d   = ST_IDLE;
					end
					ACT_CLEAR: begin
						ram_we    = found_q;
						ram_wdata = '{id: '0, waiting: 1'b0,
							retries: ent_q.retries, timer: ent_q.timer};
						state_d   = ST_IDLE;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_DRAIN: begin
				if (!pend_vld_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
			limit_q   <= RetryReset;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_RETRY:   limit_q   <= cfg_data[RetryW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action_t'(action);
			sid_q  <= sess_id;
			elap_q <= elapsed_ms;
		end
		if (issue) begin
			addr_s1 <= raddr;
		end
		if (s1_adv && match && !found_q) begin
			slot_q <= addr_s1;
			ent_q  <= ent_s1;
		end
		if (s1_adv && is_tick && rec) begin
			pend_kind_q <= res.kind;
			pend_id_q   <= ent_s1.id;
		end
		if (push) begin
			out_kind_q <= push_kind;
			out_id_q   <= push_id;
			out_last_q <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= '0;
			s1_vld_s1  <= 1'b0;
			vbit_s1    <= 1'b0;
			found_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			ev_cnt_q   <= '0;
			out_vld_q  <= 1'b0;
			valid_q    <= '0;
			next_id_q  <= IdReset;
		end else begin
			if (accept) begin
				rd_cnt_q   <= '0;
				s1_vld_s1  <= 1'b0;
				found_q    <= 1'b0;
				pend_vld_q <= 1'b0;
				ev_cnt_q   <= '0;
			end else begin
				if (issue) begin
					rd_cnt_q  <= rd_cnt_q + 1'b1;
					s1_vld_s1 <= 1'b1;
					vbit_s1   <= valid_q[raddr];
				end else if (s1_adv) begin
					s1_vld_s1 <= 1'b0;
				end
				if (s1_adv && match) begin
					found_q <= 1'b1;
				end
				if (s1_adv && is_tick && rec) begin
					pend_vld_q <= 1'b1;
					ev_cnt_q   <= ev_cnt_q + 1'b1;
				end else if (state_q == ST_DRAIN && push) begin
					pend_vld_q <= 1'b0;
				end
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (alloc_done) begin
				next_id_q <= after_id;
			end
			if (push) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	`SRTT_ASSERT_NOW(a_no_overrun, push, out_free, "output word overwritten while stalled")
	`SRTT_ASSERT_NOW(a_rw_apart, ram_we && issue, ram_waddr != raddr,
		"RAM read and write hit the same entry")
	`SRTT_ASSERT_NOW(a_ev_cap, 1'b1, ev_cnt_q <= EvCntW'(MaxResults),
		"event count beyond limit")
	`SRTT_ASSERT_NOW(a_id_nonzero, 1'b1, next_id_q != '0, "next id is zero")
	`SRTT_ASSERT_NEXT(a_drain_empty, state_q == ST_DRAIN && state_d == ST_IDLE,
		!pend_vld_q, "pending word left after tick")

endmodule

// ===== tb/sv/session_retry_timer_table_core_tb.sv =====
// Self-checking testbench for session_retry_timer_table_core: a directed table, then random
// phases under several timeout and retry settings, checked against an in-bench table model or pinned words.
// Depends on srtt_pkg and the session_retry_timer_table_core RTL.
`timescale 1ns / 1ps

module session_retry_timer_table_core_tb;
	import srtt_pkg::*;

	localparam int Slots = 16;
	localparam int Limit = 600000;

	typedef struct packed {
		event_kind_t    kind;
		logic [IdW-1:0] id;
		logic           last;
	} table_event_t;

	typedef struct packed {
		action_t           act;
		logic [IdW-1:0]    sid;
		logic [TimerW-1:0] el;
		bit                pinned;
		event_kind_t       kind;
		logic [IdW-1:0]    id;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = ACT_ALLOC;
	logic [IdW-1:0]     sess_id = '0;
	logic [TimerW-1:0]  elapsed_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         event_kind;
	logic [IdW-1:0]     event_id;
	logic               last_event;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = CFG_TIMEOUT;
	logic [CfgW-1:0]    cfg_data = '0;

	logic [IdW-1:0]    tbl_id      [Slots];
	bit                tbl_wait    [Slots];
	logic [RetryW-1:0] tbl_retries [Slots];
	logic [TimerW-1:0] tbl_timer   [Slots];
	logic [IdW-1:0]    tbl_next_id = IdReset;
	logic [TimerW-1:0] cur_timeout = TimeoutReset;
	logic [RetryW-1:0] cur_retry_limit = RetryReset;
	bit                id_wrapped = 1'b0;

	table_event_t pending_events[$];
	int           fails = 0;
	int           cycles = 0;
	bit           tx_quiet = 1'b0;
	bit           rx_quiet = 1'b0;

	plan_row_t plan [23] = '{
		'{ACT_ALLOC, 8'h00, 16'h0000, 1'b1, EV_ALLOC,  8'd1},
		'{ACT_ALLOC, 8'hFF, 16'hFFFF, 1'b1, EV_ALLOC,  8'd2},
		'{ACT_ARM,   8'h00, 16'h1234, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_ARM,   8'hAA, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_CLEAR, 8'h00, 16'hFFFF, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_CLEAR, 8'hFF, 16'h5555, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h55, 16'hFFFF, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_ARM,   8'h01, 16'hAAAA, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h00, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h00, 16'd2999, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h00, 16'd1,    1'b1, EV_RETX,   8'd1},
		'{ACT_TICK,  8'h00, 16'hFFFF, 1'b1, EV_RETX,   8'd1},
		'{ACT_TICK,  8'h00, 16'hFFFF, 1'b1, EV_RETX,   8'd1},
		'{ACT_TICK,  8'h00, 16'hFFFF, 1'b1, EV_EXPIRE, 8'd1},
		'{ACT_TICK,  8'h00, 16'hFFFF, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_ARM,   8'h02, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_ARM,   8'h01, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h00, 16'h8000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_CLEAR, 8'h01, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_ALLOC, 8'h00, 16'h0000, 1'b1, EV_ALLOC,  8'd3},
		'{ACT_CLEAR, 8'h02, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_CLEAR, 8'h03, 16'h0000, 1'b0, EV_ALLOC,  8'd0},
		'{ACT_TICK,  8'h00, 16'hFFFF, 1'b0, EV_ALLOC,  8'd0}
	};

	session_retry_timer_table_core #(
		.SESSIONS(Slots)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.sess_id    (sess_id),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.event_id   (event_id),
		.last_event (last_event),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int slot_of(logic [IdW-1:0] id);
		for (int i = 0; i < Slots; i++)
			if (tbl_id[i] == id)
				return i;
		return Slots;
	endfunction

	function automatic void bump_next_id();
		tbl_next_id = tbl_next_id + 8'd1;
		if (tbl_next_id == '0) begin
			tbl_next_id = IdReset;
			id_wrapped = 1'b1;
		end
	endfunction

	function automatic logic [IdW-1:0] pick_live_id();
		logic [IdW-1:0] live[$];
		foreach (tbl_id[i])
			if (tbl_id[i] != '0)
				live.push_back(tbl_id[i]);
		if (live.size() == 0)
			return IdW'($urandom_range(0, 255));
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	function automatic void advance_table(action_t a, logic [IdW-1:0] sid,
			logic [TimerW-1:0] el);
		int slot;
		logic [IdW-1:0] given;
		event_kind_t k;
		table_event_t evs[$];
		case (a)
		ACT_ALLOC: begin
			given = '0;
			slot = slot_of('0);
			if (slot < Slots) begin
				for (int t = 0; t < 256; t++) begin
					if (tbl_next_id != '0 && slot_of(tbl_next_id) == Slots) begin
						given = tbl_next_id;
						tbl_id[slot] = given;
						tbl_wait[slot] = 1'b0;
						tbl_timer[slot] = cur_timeout;
						bump_next_id();
						break;
					end
					bump_next_id();
				end
			end
			evs.push_back(table_event_t'{EV_ALLOC, given, 1'b0});
		end
		ACT_ARM: begin
			slot = (sid == '0) ? Slots : slot_of(sid);
			if (slot < Slots) begin
				tbl_wait[slot] = 1'b1;
				tbl_retries[slot] = '0;
				tbl_timer[slot] = cur_timeout;
			end
		end
		ACT_TICK: begin
			for (int i = 0; i < Slots; i++) begin
				if (!tbl_wait[i])
					continue;
				tbl_timer[i] = (tbl_timer[i] > el) ? tbl_timer[i] - el : '0;
				if (tbl_timer[i] != '0)
					continue;
				if (tbl_retries[i] < cur_retry_limit) begin
					tbl_timer[i] = cur_timeout;
					tbl_retries[i] = tbl_retries[i] + 8'd1;
					k = EV_RETX;
				end else begin
					tbl_wait[i] = 1'b0;
					k = EV_EXPIRE;
				end
				if (evs.size() < MaxResults)
					evs.push_back(table_event_t'{k, tbl_id[i], 1'b0});
			end
		end
		default: begin
			slot = (sid == '0) ? Slots : slot_of(sid);
			if (slot < Slots) begin
				tbl_wait[slot] = 1'b0;
				tbl_id[slot] = '0;
			end
		end
		endcase
		foreach (evs[j]) begin
			evs[j].last = (j == evs.size() - 1);
			pending_events.push_back(evs[j]);
		end
	endfunction

	task automatic drive_word(input action_t a, input logic [IdW-1:0] s,
			input logic [TimerW-1:0] e, input bit pinned = 1'b0,
			input event_kind_t pin_kind = EV_ALLOC, input logic [IdW-1:0] pin_id = '0);
		int hold;
		int base;
		bit drain;
		if ($urandom_range(0, 29) == 0)
			tx_quiet = !tx_quiet;
		hold = tx_quiet ? 0 : $urandom_range(0, 10);
		drain = ($urandom_range(0, 24) == 0);
		if (drain && hold == 0)
			hold = 1;
		if (hold > 0) begin
			in_valid <= 1'b0;
			repeat (hold) @(posedge clk);
			while (drain && pending_events.size() != 0) @(posedge clk);
		end
		base = pending_events.size();
		advance_table(a, s, e);
		if (pinned) begin
			while (pending_events.size() > base)
				pending_events.pop_back();
			pending_events.push_back(table_event_t'{pin_kind, pin_id, 1'b1});
		end
		in_valid <= 1'b1;
		action <= a;
		sess_id <= s;
		elapsed_ms <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic set_config(input logic [TimerW-1:0] tmo, input logic [RetryW-1:0] lim);
		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (Slots + 8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		cfg_index <= CFG_RETRY;
		cfg_data <= {8'h00, lim};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = tmo;
		cur_retry_limit = lim;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == Limit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int hold;
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_quiet = !rx_quiet;
			hold = rx_quiet ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		table_event_t exp_ev;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected word: event_kind %0d event_id %0d last_event %0d",
					event_kind, event_id, last_event);
				fails++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (event_kind !== exp_ev.kind) begin
					$error("event_kind: expected %0d, got %0d", exp_ev.kind, event_kind);
					fails++;
				end
				if (event_id !== exp_ev.id) begin
					$error("event_id: expected %0d, got %0d", exp_ev.id, event_id);
					fails++;
				end
				if (last_event !== exp_ev.last) begin
					$error("last_event: expected %0d, got %0d", exp_ev.last, last_event);
					fails++;
				end
			end
		end
	end

	initial begin
		logic [TimerW-1:0] tmo;
		logic [RetryW-1:0] lim;
		logic [TimerW-1:0] el;
		int cap;
		int r;
		action_t a;
		for (int i = 0; i < Slots; i++) begin
			tbl_id[i] = '0;
			tbl_wait[i] = 1'b0;
			tbl_retries[i] = '0;
			tbl_timer[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			drive_word(plan[i].act, plan[i].sid, plan[i].el, plan[i].pinned,
				plan[i].kind, plan[i].id);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
			0: begin
				tmo = 16'd100;
				lim = 8'd2;
			end
			1: begin
				tmo = 16'd0;
				lim = 8'd1;
			end
			2: begin
				tmo = 16'hFFFF;
				lim = 8'hFF;
			end
			3: begin
				tmo = TimerW'($urandom_range(1, 400));
				lim = 8'd0;
			end
			default: begin
				tmo = TimeoutReset;
				lim = RetryReset;
			end
			endcase
			set_config(tmo, lim);

			// fill the table, arm every entry, and let all of them come due together
			if (ph == 1) begin
				for (int i = 0; i < Slots; i++)
					if (tbl_id[i] != '0)
						drive_word(ACT_CLEAR, tbl_id[i], TimerW'($urandom));
				repeat (Slots + 1)
					drive_word(ACT_ALLOC, IdW'($urandom), TimerW'($urandom));
				for (int i = 0; i < Slots; i++)
					drive_word(ACT_ARM, tbl_id[i], TimerW'($urandom));
				repeat (2)
					drive_word(ACT_TICK, IdW'($urandom), TimerW'($urandom));
			end

			repeat (30) begin
				r = $urandom_range(0, 99);
				a = (r < 30) ? ACT_ALLOC : (r < 55) ? ACT_ARM : (r < 80) ? ACT_TICK : ACT_CLEAR;
				cap = int'(cur_timeout) * 2 + 1;
				if (cap > 65535)
					cap = 65535;
				case ($urandom_range(0, 7))
				0: el = '0;
				1: el = 16'hFFFF;
				2, 3, 4, 5: el = TimerW'($urandom_range(0, cap));
				default: el = TimerW'($urandom);
				endcase
				if ((a == ACT_ARM || a == ACT_CLEAR) && $urandom_range(0, 3) != 0)
					drive_word(a, pick_live_id(), el);
				else
					drive_word(a, IdW'($urandom), el);
			end
		end

		// churn allocate and clear pairs
		for (int n = 0; n < 15 && !id_wrapped; n++) begin
			drive_word(ACT_ALLOC, IdW'($urandom), TimerW'($urandom));
			drive_word(ACT_CLEAR, pick_live_id(), TimerW'($urandom));
		end

		in_valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (Slots + 8) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
